// ===== src/linked_node_pool_manager_defines.svh =====
// ------------------------------------------------------------------------
// linked node pool manager assertion macros
// concurrent assertion wrappers, compiled out for synthesis
// ------------------------------------------------------------------------
`ifndef LINKED_NODE_POOL_MANAGER_DEFINES_SVH
`define LINKED_NODE_POOL_MANAGER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication on clk, off during reset
`define LNPM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication on clk, off during reset
`define LNPM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LNPM_ASSERT_NOW(label, ante, cons, msg)
`define LNPM_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== src/lnpm_pkg.sv =====
// ------------------------------------------------------------------------
// lnpm_pkg
// shared types, codes and helpers of the linked node pool manager
// ------------------------------------------------------------------------
package lnpm_pkg;

	// default pool size and span of an 8-bit pointer
	localparam int LNPM_POOL_NODES = 255;
	localparam int LNPM_PTR_SPAN   = 256;

	typedef logic [7:0]         ptr_t;
	typedef logic signed [31:0] item_t;

	// command codes
	typedef enum logic [3:0] {
		CMD_ALLOC       = 4'd0,
		CMD_FREE        = 4'd1,
		CMD_LINK_BASE   = 4'd2,
		CMD_UNLINK_BASE = 4'd3,
		CMD_READ        = 4'd4,
		CMD_SET_CUR     = 4'd5,
		CMD_LINK_CUR    = 4'd6,
		CMD_UNLINK_CUR  = 4'd7,
		CMD_ADVANCE     = 4'd8,
		CMD_GET_CUR     = 4'd9
	} cmd_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_NULL  = 2'd2
	} status_t;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_FIRST,
		S_SECOND,
		S_FINISH
	} state_t;

	// one access to the link memory per cycle
	typedef struct packed {
		logic rd;
		logic wr;
		ptr_t addr;
		ptr_t wdata;
	} link_req_t;

	// depth actually reachable through an 8-bit pointer
	function automatic int lnpm_depth(input int pool);
		return (pool < LNPM_PTR_SPAN - 1) ? pool + 1 : LNPM_PTR_SPAN;
	endfunction

	// nonzero and inside the pool
	function automatic logic lnpm_is_node(input ptr_t p, input int pool);
		return (p != '0) && (int'(p) <= pool);
	endfunction

endpackage

// ===== src/lnpm_ram.sv =====
// ------------------------------------------------------------------------
// lnpm_ram
// generic single write, single read memory with registered read data
// ------------------------------------------------------------------------
module lnpm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/lnpm_link_store.sv =====
// ------------------------------------------------------------------------
// lnpm_link_store
// next-pointer memory with per-entry valid bits standing in for the
// in-order chain present after reset
// ------------------------------------------------------------------------
`include "linked_node_pool_manager_defines.svh"

module lnpm_link_store
	import lnpm_pkg::*;
#(
	parameter int POOL_NODES = LNPM_POOL_NODES
) (
	input  logic      clk,
	input  logic      arst_n,
	input  link_req_t req,
	output ptr_t      rdata
);

	localparam int NODE_DEPTH = lnpm_depth(POOL_NODES);
	localparam int ADDR_W     = $clog2(NODE_DEPTH);

	logic [NODE_DEPTH-1:0] valid_q;
	logic [ADDR_W-1:0]     addr;
	logic [ADDR_W-1:0]     raddr_q;
	logic                  rvalid_q;
	ptr_t                  ram_rdata;
	ptr_t                  init_val;

	assign addr = req.addr[ADDR_W-1:0];

	lnpm_ram #(
		.WIDTH($bits(ptr_t)),
		.DEPTH(NODE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (req.wr),
		.waddr (addr),
		.wdata (req.wdata),
		.re    (req.rd),
		.raddr (addr),
		.rdata (ram_rdata)
	);

	// valid bits: an entry holds its reset link until first written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.wr) begin
			valid_q[addr] <= 1'b1;
		end
	end

	// remember address and validity alongside the registered read
	always_ff @(posedge clk) begin
		if (req.rd) begin
			raddr_q  <= addr;
			rvalid_q <= valid_q[addr];
		end
	end

	// reset chain: entry i points to i+1, the last entry to null
	always_comb begin
		if (int'(raddr_q) == POOL_NODES) begin
			init_val = '0;
		end else begin
			init_val = ptr_t'(int'(raddr_q) + 1);
		end
	end

	assign rdata = rvalid_q ? ram_rdata : init_val;

	`LNPM_ASSERT_NOW(a_rd_wr_excl, req.wr, !req.rd, "link read and write in one cycle")
	`LNPM_ASSERT_NOW(a_wr_not_null, req.wr, req.addr != '0, "link write to the free list head")
	`LNPM_ASSERT_NOW(a_wr_in_pool, req.wr, int'(req.addr) <= POOL_NODES, "link write out of pool")

endmodule

// ===== src/linked_node_pool_manager.sv =====
// ------------------------------------------------------------------------
// linked_node_pool_manager
// pool of linked nodes with a free list, a current-node pointer and
// link, unlink and read commands, run by a small sequencer around one
// next-pointer memory port
// ------------------------------------------------------------------------
//  channel   handshake          word
//  command   start / busy       command, node_arg, base_arg, item_in
//  result    done (strobe)      node_out, next_out, item_out, status
//
//  sequencing after the accepting edge: free, set_current, current query,
//  unknown codes, argument errors and alloc on an empty pool answer from
//  idle; alloc, read, advance and unlink onto a null successor pass through
//  S_FIRST; link adds S_FINISH and unlink S_SECOND. the single port of the
//  link memory with its registered read sets this sequencing.
//  busy falls with done, so the next word may start in the done cycle.
//  reset: free list chained in order, current pointer null, no clearing
//  pass. the receiver cannot stall: done lasts exactly one cycle.
// ------------------------------------------------------------------------
`include "linked_node_pool_manager_defines.svh"

module linked_node_pool_manager
	import lnpm_pkg::*;
#(
	parameter int POOL_NODES = LNPM_POOL_NODES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [3:0]         command,
	input  logic [7:0]         node_arg,
	input  logic [7:0]         base_arg,
	input  logic signed [31:0] item_in,
	output logic               done,
	output logic [7:0]         node_out,
	output logic [7:0]         next_out,
	output logic signed [31:0] item_out,
	output logic [1:0]         status
);

	localparam int NODE_DEPTH = lnpm_depth(POOL_NODES);
	localparam int ADDR_W     = $clog2(NODE_DEPTH);

	state_t            state_q, state_d;
	ptr_t              head_q, head_d;
	ptr_t              cur_q, cur_d;
	ptr_t              a_q, a_d;
	ptr_t              t_q, t_d;
	logic [3:0]        cmd_q;
	item_t             item_arg_q;
	link_req_t         link_req;
	ptr_t              link_rdata;
	logic              item_we, item_re;
	logic [ADDR_W-1:0] item_addr;
	item_t             item_rdata;
	logic              done_q, done_d;
	ptr_t              res_node_q, res_node_d;
	ptr_t              res_next_q, res_next_d;
	item_t             res_item_q, res_item_d;
	status_t           res_status_q, res_status_d;

	assign busy = (state_q != S_IDLE);

	lnpm_link_store #(
		.POOL_NODES(POOL_NODES)
	) u_links (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (link_req),
		.rdata  (link_rdata)
	);

	lnpm_ram #(
		.WIDTH($bits(item_t)),
		.DEPTH(NODE_DEPTH)
	) u_items (
		.clk   (clk),
		.we    (item_we),
		.waddr (item_addr),
		.wdata (item_arg_q),
		.re    (item_re),
		.raddr (item_addr),
		.rdata (item_rdata)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// free list head, current pointer and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= ptr_t'(1);
			cur_q  <= '0;
			done_q <= 1'b0;
		end else begin
			head_q <= head_d;
			cur_q  <= cur_d;
			done_q <= done_d;
		end
	end

	// command word and operand registers
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_q      <= command;
			item_arg_q <= item_in;
		end
		a_q <= a_d;
		t_q <= t_d;
	end

	// result word register
	always_ff @(posedge clk) begin
		if (done_d) begin
			res_node_q   <= res_node_d;
			res_next_q   <= res_next_d;
			res_item_q   <= res_item_d;
			res_status_q <= res_status_d;
		end
	end

	// sequencer: next state, memory accesses and result
	always_comb begin
		state_d      = state_q;
		head_d       = head_q;
		cur_d        = cur_q;
		a_d          = a_q;
		t_d          = t_q;
		link_req     = '0;
		item_we      = 1'b0;
		item_re      = 1'b0;
		item_addr    = '0;
		done_d       = 1'b0;
		res_node_d   = '0;
		res_next_d   = '0;
		res_item_d   = '0;
		res_status_d = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					done_d = 1'b1;
					t_d    = node_arg;
					unique case (command) inside
						CMD_ALLOC: begin
							if (!lnpm_is_node(head_q, POOL_NODES)) begin
								res_status_d = ST_EMPTY;
							end else begin
								done_d        = 1'b0;
								link_req.rd   = 1'b1;
								link_req.addr = head_q;
								a_d           = head_q;
								state_d       = S_FIRST;
							end
						end
						CMD_FREE: begin
							if (!lnpm_is_node(node_arg, POOL_NODES)) begin
								res_status_d = ST_NULL;
							end else begin
								link_req.wr    = 1'b1;
								link_req.addr  = node_arg;
								link_req.wdata = head_q;
								head_d         = node_arg;
								res_node_d     = node_arg;
							end
						end
						CMD_LINK_BASE, CMD_LINK_CUR: begin
							a_d = (command == CMD_LINK_BASE) ? base_arg : cur_q;
							if (!lnpm_is_node(a_d, POOL_NODES) ||
								!lnpm_is_node(node_arg, POOL_NODES)) begin
								res_status_d = ST_NULL;
							end else begin
								done_d        = 1'b0;
								link_req.rd   = 1'b1;
								link_req.addr = a_d;
								state_d       = S_FIRST;
							end
						end
						CMD_UNLINK_BASE, CMD_UNLINK_CUR: begin
							a_d = (command == CMD_UNLINK_BASE) ? base_arg : cur_q;
							if (!lnpm_is_node(a_d, POOL_NODES)) begin
								res_status_d = ST_NULL;
							end else begin
								done_d        = 1'b0;
								link_req.rd   = 1'b1;
								link_req.addr = a_d;
								state_d       = S_FIRST;
							end
						end
						CMD_READ: begin
							a_d = base_arg;
							if (!lnpm_is_node(base_arg, POOL_NODES)) begin
								res_status_d = ST_NULL;
							end else begin
								done_d        = 1'b0;
								link_req.rd   = 1'b1;
								link_req.addr = base_arg;
								item_re       = 1'b1;
								item_addr     = base_arg[ADDR_W-1:0];
								state_d       = S_FIRST;
							end
						end
						CMD_SET_CUR: begin
							if (!lnpm_is_node(node_arg, POOL_NODES)) begin
								res_status_d = ST_NULL;
							end else begin
								cur_d          = node_arg;
								link_req.wr    = 1'b1;
								link_req.addr  = node_arg;
								link_req.wdata = node_arg;
								res_node_d     = node_arg;
							end
						end
						CMD_ADVANCE: begin
							a_d = cur_q;
							if (!lnpm_is_node(cur_q, POOL_NODES)) begin
								res_status_d = ST_NULL;
							end else begin
								done_d        = 1'b0;
								link_req.rd   = 1'b1;
								link_req.addr = cur_q;
								state_d       = S_FIRST;
							end
						end
						CMD_GET_CUR: begin
							res_node_d = cur_q;
						end
						default: begin
							// unused codes answer all zero with ok status
						end
					endcase
				end
			end
			S_FIRST: begin
				// link of the anchor node is on link_rdata
				state_d = S_IDLE;
				done_d  = 1'b1;
				case (cmd_q) inside
					CMD_ALLOC: begin
						link_req.wr    = 1'b1;
						link_req.addr  = a_q;
						link_req.wdata = a_q;
						item_we        = 1'b1;
						item_addr      = a_q[ADDR_W-1:0];
						head_d         = link_rdata;
						res_node_d     = a_q;
						res_item_d     = item_arg_q;
					end
					CMD_LINK_BASE, CMD_LINK_CUR: begin
						link_req.wr    = 1'b1;
						link_req.addr  = t_q;
						link_req.wdata = link_rdata;
						done_d         = 1'b0;
						state_d        = S_FINISH;
					end
					CMD_UNLINK_BASE, CMD_UNLINK_CUR: begin
						if (!lnpm_is_node(link_rdata, POOL_NODES)) begin
							res_status_d = ST_NULL;
						end else begin
							// t_q takes the node being removed, for S_SECOND
							link_req.rd   = 1'b1;
							link_req.addr = link_rdata;
							item_re       = 1'b1;
							item_addr     = link_rdata[ADDR_W-1:0];
							t_d           = link_rdata;
							done_d        = 1'b0;
							state_d       = S_SECOND;
						end
					end
					CMD_READ: begin
						res_node_d = a_q;
						res_next_d = link_rdata;
						res_item_d = item_rdata;
					end
					CMD_ADVANCE: begin
						cur_d      = link_rdata;
						res_node_d = link_rdata;
					end
					default: begin
						// not reached: other commands finish in idle
					end
				endcase
			end
			S_SECOND: begin
				// unlink: bypass the removed node
				link_req.wr    = 1'b1;
				link_req.addr  = a_q;
				link_req.wdata = link_rdata;
				res_node_d     = t_q;
				res_item_d     = item_rdata;
				done_d         = 1'b1;
				state_d        = S_IDLE;
			end
			S_FINISH: begin
				// link: anchor points to the inserted node
				link_req.wr    = 1'b1;
				link_req.addr  = a_q;
				link_req.wdata = t_q;
				res_node_d     = t_q;
				done_d         = 1'b1;
				state_d        = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign done     = done_q;
	assign node_out = res_node_q;
	assign next_out = res_next_q;
	assign item_out = res_item_q;
	assign status   = res_status_q;

	`LNPM_ASSERT_NEXT(a_done_src, !busy && !start, !done, "result without a command word")
	`LNPM_ASSERT_NOW(a_err_zero, done && status != ST_OK, node_out == '0 && next_out == '0 && item_out == '0, "error result carries data")
	`LNPM_ASSERT_NEXT(a_head_hold, !(state_q == S_FIRST && cmd_q == CMD_ALLOC) && !(start && !busy && command == CMD_FREE), $stable(head_q), "free list head moved outside alloc or free")

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// tb
// self-checking bench for linked_node_pool_manager: command words are
// driven over start / busy, a pool model in the bench predicts every
// result word, and each done strobe is checked field by field
// ------------------------------------------------------------------------
module tb
	import lnpm_pkg::*;
();

	localparam int CYCLE_LIMIT = 200000;

	// one predicted result word
	typedef struct {
		ptr_t    node;
		ptr_t    nxt;
		item_t   item;
		status_t st;
	} pool_reply_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [3:0]        command;
	ptr_t              node_arg;
	ptr_t              base_arg;
	item_t             item_in;
	logic              done;
	ptr_t              node_out;
	ptr_t              next_out;
	item_t             item_out;
	logic [1:0]        status;

	// bench copy of the pool
	ptr_t              pool_links [LNPM_PTR_SPAN];
	item_t             pool_items [LNPM_PTR_SPAN];
	bit                item_written [LNPM_PTR_SPAN];
	ptr_t              written_nodes [$];
	ptr_t              cur_node;

	pool_reply_t       pool_replies_q [$];
	pool_reply_t       want;
	int                mismatch_count;
	int                cycle_count;
	int                sender_idle_pct;

	linked_node_pool_manager dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.command  (command),
		.node_arg (node_arg),
		.base_arg (base_arg),
		.item_in  (item_in),
		.done     (done),
		.node_out (node_out),
		.next_out (next_out),
		.item_out (item_out),
		.status   (status)
	);

	// 100 MHz clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timeout, %0d result words still pending", $time,
			pool_replies_q.size());
		$display("tb: done, errors");
		$finish;
	end

	function automatic bit is_pool_node(input ptr_t p);
		return (p != 8'd0) && (int'(p) <= LNPM_POOL_NODES);
	endfunction

	// pool state after reset: free list chained in order
	function automatic void reset_pool_model();
		for (int i = 0; i < LNPM_PTR_SPAN; i++) begin
			pool_links[i]   = (i < LNPM_POOL_NODES) ? ptr_t'(i + 1) : 8'd0;
			pool_items[i]   = '0;
			item_written[i] = 1'b0;
		end
		written_nodes.delete();
		cur_node = 8'd0;
	endfunction

	// update the pool for one accepted word and queue its result
	function automatic void apply_pool_command(input logic [3:0] cmd, input ptr_t t,
		input ptr_t x, input item_t v);
		pool_reply_t r;
		ptr_t        anchor;
		ptr_t        victim;
		r.node = 8'd0;
		r.nxt  = 8'd0;
		r.item = '0;
		r.st   = ST_OK;
		anchor = (cmd == CMD_LINK_BASE || cmd == CMD_UNLINK_BASE) ? x : cur_node;
		case (cmd)
			CMD_ALLOC: begin
				victim = pool_links[0];
				if (!is_pool_node(victim)) begin
					r.st = ST_EMPTY;
				end else begin
					pool_links[0]      = pool_links[victim];
					pool_items[victim] = v;
					pool_links[victim] = victim;
					if (!item_written[victim]) begin
						item_written[victim] = 1'b1;
						written_nodes.push_back(victim);
					end
					r.node = victim;
					r.item = v;
				end
			end
			CMD_FREE: begin
				if (!is_pool_node(t)) begin
					r.st = ST_NULL;
				end else begin
					pool_links[t] = pool_links[0];
					pool_links[0] = t;
					r.node        = t;
				end
			end
			CMD_LINK_BASE, CMD_LINK_CUR: begin
				if (!is_pool_node(anchor) || !is_pool_node(t)) begin
					r.st = ST_NULL;
				end else begin
					pool_links[t]      = pool_links[anchor];
					pool_links[anchor] = t;
					r.node             = t;
				end
			end
			CMD_UNLINK_BASE, CMD_UNLINK_CUR: begin
				if (!is_pool_node(anchor) || !is_pool_node(pool_links[anchor])) begin
					r.st = ST_NULL;
				end else begin
					victim             = pool_links[anchor];
					pool_links[anchor] = pool_links[victim];
					r.node             = victim;
					r.item             = pool_items[victim];
				end
			end
			CMD_READ: begin
				if (!is_pool_node(x)) begin
					r.st = ST_NULL;
				end else begin
					r.node = x;
					r.nxt  = pool_links[x];
					r.item = pool_items[x];
				end
			end
			CMD_SET_CUR: begin
				if (!is_pool_node(t)) begin
					r.st = ST_NULL;
				end else begin
					cur_node      = t;
					pool_links[t] = t;
					r.node        = t;
				end
			end
			CMD_ADVANCE: begin
				if (!is_pool_node(cur_node)) begin
					r.st = ST_NULL;
				end else begin
					cur_node = pool_links[cur_node];
					r.node   = cur_node;
				end
			end
			CMD_GET_CUR: begin
				r.node = cur_node;
			end
			default: begin
			end
		endcase
		pool_replies_q.push_back(r);
	endfunction

	// a read or unlink that would return an item never stored
	function automatic bit reads_unwritten(input logic [3:0] cmd, input ptr_t x);
		ptr_t anchor;
		anchor = (cmd == CMD_UNLINK_BASE) ? x : cur_node;
		case (cmd)
			CMD_READ:
				return is_pool_node(x) && !item_written[x];
			CMD_UNLINK_BASE, CMD_UNLINK_CUR:
				return is_pool_node(anchor) && is_pool_node(pool_links[anchor])
					&& !item_written[pool_links[anchor]];
			default:
				return 1'b0;
		endcase
	endfunction

	// mostly live nodes, sometimes null or anything
	function automatic ptr_t pick_node();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return 8'd0;
		if (r < 30 || written_nodes.size() == 0)
			return ptr_t'($urandom_range(255));
		return written_nodes[$urandom_range(written_nodes.size() - 1)];
	endfunction

	function automatic logic [3:0] pick_command(input int alloc_pct);
		if ($urandom_range(99) < alloc_pct)
			return CMD_ALLOC;
		if ($urandom_range(99) < 5)
			return 4'($urandom_range(10, 15));
		return 4'($urandom_range(1, 9));
	endfunction

	function automatic item_t pick_item();
		case ($urandom_range(19))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return '0;
			3: return -32'sd1;
			default: return item_t'($urandom);
		endcase
	endfunction

	// offer one word after a random idle stretch, return at the accepting edge
	task automatic send_word(input logic [3:0] cmd, input ptr_t t, input ptr_t x,
		input item_t v);
		while ($urandom_range(99) < sender_idle_pct) begin
			start    <= 1'b0;
			command  <= 4'($urandom);
			node_arg <= 8'($urandom);
			base_arg <= 8'($urandom);
			item_in  <= item_t'($urandom);
			@(posedge clk);
		end
		start    <= 1'b1;
		command  <= cmd;
		node_arg <= t;
		base_arg <= x;
		item_in  <= v;
		do
			@(posedge clk);
		while (busy);
		apply_pool_command(cmd, t, x, v);
	endtask

	// stop offering and wait for every pending result word
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pool_replies_q.size() != 0)
			@(posedge clk);
	endtask

	// compare one field of a result word
	task automatic report_field(input string field, input logic [31:0] exp_v,
		input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			mismatch_count++;
			$display("%0t: %s expected %0h actual %0h", $time, field, exp_v, act_v);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pool_replies_q.size() == 0) begin
				mismatch_count++;
				$display("%0t: result word with none expected, expected none actual node %0h",
					$time, node_out);
			end else begin
				want = pool_replies_q.pop_front();
				report_field("node_out", 32'(want.node), 32'(node_out));
				report_field("next_out", 32'(want.nxt), 32'(next_out));
				report_field("item_out", want.item, item_out);
				report_field("status", 32'(want.st), 32'(status));
			end
		end
	end

	// commands that need a current node while it is still null
	task automatic test_null_current();
		send_word(CMD_GET_CUR, 8'd0, 8'd0, '0);
		send_word(CMD_ADVANCE, 8'd0, 8'd0, '0);
		send_word(CMD_LINK_CUR, 8'd1, 8'd0, '0);
		send_word(CMD_UNLINK_CUR, 8'd0, 8'd0, '0);
	endtask

	// allocate nodes 1 to 4 with extreme items
	task automatic test_alloc_extremes();
		send_word(CMD_ALLOC, 8'hff, 8'hff, 32'sh7fffffff);
		send_word(CMD_ALLOC, 8'd0, 8'd0, 32'sh80000000);
		send_word(CMD_ALLOC, 8'h55, 8'haa, -32'sd1);
		send_word(CMD_ALLOC, 8'haa, 8'h55, '0);
	endtask

	// null node and base arguments
	task automatic test_null_args();
		send_word(CMD_READ, 8'd0, 8'd0, '0);
		send_word(CMD_READ, 8'd0, 8'd1, '0);
		send_word(CMD_FREE, 8'd0, 8'd0, '0);
		send_word(CMD_LINK_BASE, 8'd0, 8'd1, '0);
		send_word(CMD_LINK_BASE, 8'd2, 8'd0, '0);
	endtask

	// link after a base, link onto itself, unlink, unlink with null successor
	task automatic test_link_unlink();
		send_word(CMD_LINK_BASE, 8'd2, 8'd1, '0);
		send_word(CMD_LINK_BASE, 8'd3, 8'd3, '0);
		send_word(CMD_UNLINK_BASE, 8'd0, 8'd1, '0);
		send_word(CMD_UNLINK_BASE, 8'd0, 8'hff, '0);
	endtask

	// current node: set, walk off the end to null, link and unlink after it
	task automatic test_current_walk();
		send_word(CMD_SET_CUR, 8'd0, 8'd0, '0);
		send_word(CMD_SET_CUR, 8'd1, 8'd0, '0);
		send_word(CMD_LINK_BASE, 8'd1, 8'hff, '0);
		send_word(CMD_ADVANCE, 8'd0, 8'd0, '0);
		send_word(CMD_SET_CUR, 8'd4, 8'd0, '0);
		send_word(CMD_LINK_CUR, 8'd3, 8'd0, '0);
		send_word(CMD_UNLINK_CUR, 8'd0, 8'd0, '0);
	endtask

	task automatic test_unknown_codes();
		send_word(4'd10, 8'hff, 8'hff, -32'sd1);
		send_word(4'd15, 8'd1, 8'd1, 32'sh12345678);
	endtask

	// alloc-heavy run with reads of live nodes until the pool runs dry
	task automatic test_pool_exhaust(input int count);
		logic [3:0] cmd;
		for (int i = 0; i < count; i++) begin
			cmd = ($urandom_range(99) < 90) ? CMD_ALLOC : CMD_READ;
			send_word(cmd, pick_node(),
				written_nodes[$urandom_range(written_nodes.size() - 1)], pick_item());
		end
	endtask

	// random command mix over live nodes with some noise
	task automatic test_random_mix(input int count);
		logic [3:0] cmd;
		ptr_t       t;
		ptr_t       x;
		for (int i = 0; i < count; i++) begin
			do begin
				cmd = pick_command(15);
				t   = pick_node();
				x   = pick_node();
			end while (reads_unwritten(cmd, x));
			send_word(cmd, t, x, pick_item());
		end
	endtask

	// main sequence
	initial begin
		mismatch_count  = 0;
		sender_idle_pct = 14;
		reset_pool_model();
		arst_n   <= 1'b0;
		start    <= 1'b0;
		command  <= 4'd0;
		node_arg <= 8'd0;
		base_arg <= 8'd0;
		item_in  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		test_null_current();
		test_alloc_extremes();
		test_null_args();
		test_link_unlink();
		test_current_walk();
		test_unknown_codes();
		test_pool_exhaust(300);
		test_random_mix(450);
		drain_results();

		sender_idle_pct = 72;
		test_random_mix(500);

		sender_idle_pct = 0;
		test_random_mix(450);

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
